/* sv/first_fit_box_placer_top_macros.svh */
// Assertion macros shared by the box placer RTL.
`ifndef FIRST_FIT_BOX_PLACER_TOP_MACROS_SVH
`define FIRST_FIT_BOX_PLACER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define FBP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box placer assertion failed");
// Next-cycle implication.
`define FBP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box placer assertion failed");
`else
`define FBP_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define FBP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* sv/fbp_pkg.sv */
// Shared types and constants of the first-fit box placer.
package fbp_pkg;

  // Width of the request, register and result coordinate fields.
  localparam int FIELD_BITS = 10;
  // Width of the coordinates kept for each stored box.
  localparam int COORD_BITS = FIELD_BITS;
  // Candidate row: start row below the grid height plus one step per stored box.
  localparam int CAND_Y_BITS = FIELD_BITS + 1;
  localparam int CFG_IDX_BITS = 2;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

  // Result status codes.
  localparam logic [1:0] ST_PLACED = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SWEEP,
    S_FINISH
  } fbp_state_t;

  // Candidate position travelling down the chain of cells.
  typedef struct packed {
    logic                   vld;
    logic                   chg;
    logic [CAND_Y_BITS-1:0] y;
    logic [FIELD_BITS-1:0]  x;
  } token_t;

  // Request under search, seen by every cell.
  typedef struct packed {
    logic [FIELD_BITS-1:0] h;
    logic [FIELD_BITS-1:0] w;
    logic [FIELD_BITS-1:0] sw;
  } sweep_ctx_t;

endpackage

/* sv/fbp_if.sv */
// Handshake channels for request and result words.
interface fbp_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] box_height;
  logic [9:0] box_width;

  modport source (output valid, output box_height, output box_width, input ready);
  modport sink (input valid, input box_height, input box_width, output ready);
endinterface

interface fbp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [9:0] top_row;
  logic [9:0] left_col;
  logic       rest_valid;
  logic [9:0] rest_top;
  logic [9:0] rest_rows;

  modport source (output valid, output status, output top_row, output left_col,
                  output rest_valid, output rest_top, output rest_rows, input ready);
  modport sink (input valid, input status, input top_row, input left_col,
                input rest_valid, input rest_top, input rest_rows, output ready);
endinterface

/* sv/fbp_cell.sv */
// One chain cell: holds one stored box and moves the candidate past it.
module fbp_cell #(
  parameter int IDX        = 0,
  parameter int CNT_W      = 5
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fbp_pkg::token_t                tin,
  input  fbp_pkg::sweep_ctx_t            ctx,
  input  logic [CNT_W-1:0]               count,
  input  logic                           wr_en,
  input  logic [fbp_pkg::COORD_BITS-1:0] wr_top,
  input  logic [fbp_pkg::COORD_BITS-1:0] wr_left,
  input  logic [fbp_pkg::COORD_BITS-1:0] wr_rows,
  input  logic [fbp_pkg::COORD_BITS-1:0] wr_cols,
  output fbp_pkg::token_t                tout
);
  import fbp_pkg::*;

  localparam int WW = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;
  localparam logic [CNT_W:0] IDX_C = (CNT_W + 1)'(IDX);

  logic [COORD_BITS-1:0] b_top, b_left, b_rows, b_cols;
  logic                  active, ov;
  logic [WW-1:0]         bl, bt, br, bb, cx, cy, cxw, cyh, rw;
  token_t                t_next;

  // Store this cell's box when it is the next free slot.
  always_ff @(posedge clk) begin
    if (wr_en && ({1'b0, count} == IDX_C)) begin
      b_top  <= wr_top;
      b_left <= wr_left;
      b_rows <= wr_rows;
      b_cols <= wr_cols;
    end
  end

  // Test half-open overlap and pick the next candidate.
  always_comb begin
    active = ({1'b0, count} > IDX_C);
    bl  = WW'(b_left);
    bt  = WW'(b_top);
    br  = WW'(b_left) + WW'(b_cols);
    bb  = WW'(b_top) + WW'(b_rows);
    cx  = WW'(tin.x);
    cy  = WW'(tin.y);
    cxw = cx + WW'(ctx.w);
    cyh = cy + WW'(ctx.h);
    rw  = br + WW'(ctx.w);
    ov  = (bl < cxw) && (cx < br) && (bt < cyh) && (cy < bb);
    t_next = tin;
    if (active && ov) begin
      t_next.chg = 1'b1;
      if (rw <= WW'(ctx.sw)) begin
        t_next.x = br[FIELD_BITS-1:0];
      end else begin
        t_next.y = tin.y + CAND_Y_BITS'(1);
        t_next.x = '0;
      end
    end
  end

  // Hand the candidate to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tout.vld <= 1'b0;
    end else begin
      tout.vld <= tin.vld;
    end
    tout.chg <= t_next.chg;
    tout.y   <= t_next.y;
    tout.x   <= t_next.x;
  end

endmodule

/* sv/first_fit_box_placer_top.sv */
// Top level of the first-fit box placer: controller and chain of cells.
//
// Usage: a request word (box_height, box_width) enters on in_ch; one result
// word (status, top_row, left_col and the free strip below the lowest box)
// leaves on out_ch for every request. screen_width and screen_height are
// written through cfg_we / cfg_idx / cfg_data while the block is idle.
// Requests are handled one at a time. The candidate position travels down a
// chain of MAX_BOXES cells, one cell per cycle, each cell holding one stored
// box. Sweeps over the store repeat until a sweep leaves the candidate
// unchanged or the box no longer fits below the candidate row; no sweep is
// run when the box is too tall for the grid at row zero. The next request
// can be taken in the same cycle that the result word becomes valid.
// The result sits in an output register: a new request is accepted while it
// waits. If the receiver stalls, the next finished result holds inside the
// controller until the output register frees up.
// Reset (rst, synchronous) empties the store, clears the lowest edge and
// sets the grid to 80 by 24; stored boxes need no clearing pass.
`include "first_fit_box_placer_top_macros.svh"

module first_fit_box_placer_top #(
  parameter int MAX_BOXES  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  fbp_in_if.sink                           in_ch,
  fbp_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [fbp_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [fbp_pkg::FIELD_BITS-1:0]   cfg_data
);
  import fbp_pkg::*;

  localparam int CNT_W = $clog2(MAX_BOXES + 1);
  localparam int LW    = (COORD_BITS > 12) ? COORD_BITS : 12;

  fbp_state_t             state, state_next;
  logic [FIELD_BITS-1:0]  screen_width, screen_height;
  logic [FIELD_BITS-1:0]  req_h, req_w;
  logic [CAND_Y_BITS-1:0] cand_y;
  logic [FIELD_BITS-1:0]  cand_x;
  logic                   no_fit;
  logic [CNT_W-1:0]       count;
  logic [COORD_BITS-1:0]  lowest;

  logic                   out_vld;
  logic [1:0]             out_status;
  logic [FIELD_BITS-1:0]  out_top, out_left, out_rest_top, out_rest_rows;
  logic                   out_rest_valid;

  logic                   slot_free, accept, inject, too_tall, take_tail;
  logic                   finish_go, place, fits;
  logic [LW-1:0]          yh, xw, y_w, x_w, h_w, w_w, low_w, low_new, sh_w, sw_w;
  logic [1:0]             status_c;
  sweep_ctx_t             ctx;
  token_t                 link [MAX_BOXES+1];

  assign slot_free = !out_vld || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign accept = in_ch.valid && in_ch.ready;

  // Widen coordinates for tests against the grid.
  always_comb begin
    y_w   = LW'(cand_y);
    x_w   = LW'(cand_x);
    h_w   = LW'(req_h);
    w_w   = LW'(req_w);
    sh_w  = LW'(screen_height);
    sw_w  = LW'(screen_width);
    low_w = LW'(lowest);
    yh    = y_w + h_w;
    xw    = x_w + w_w;
    too_tall = yh > sh_w;
    fits  = !no_fit && (xw <= sw_w) && (yh <= sh_w);
    if (!fits) begin
      status_c = ST_NO_FIT;
    end else if (count >= CNT_W'(MAX_BOXES)) begin
      status_c = ST_FULL;
    end else begin
      status_c = ST_PLACED;
    end
  end

  // Sequence the sweeps and the result.
  always_comb begin
    state_next = state;
    inject     = 1'b0;
    take_tail  = 1'b0;
    finish_go  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (too_tall) begin
          state_next = S_FINISH;
        end else begin
          inject     = 1'b1;
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (link[MAX_BOXES].vld) begin
          take_tail  = 1'b1;
          state_next = link[MAX_BOXES].chg ? S_CHECK : S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          finish_go  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign place   = finish_go && (status_c == ST_PLACED);
  assign low_new = (place && (yh > low_w)) ? LW'(yh[COORD_BITS-1:0]) : low_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Write configuration registers; ignore unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= FIELD_BITS'(80);
      screen_height <= FIELD_BITS'(24);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load the request and advance the candidate.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_h  <= in_ch.box_height;
      req_w  <= in_ch.box_width;
      cand_y <= '0;
      cand_x <= '0;
      no_fit <= 1'b0;
    end else if (state == S_CHECK && too_tall) begin
      no_fit <= 1'b1;
    end else if (take_tail) begin
      cand_y <= link[MAX_BOXES].y;
      cand_x <= link[MAX_BOXES].x;
    end
  end

  // Track fill count and lowest edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      lowest <= '0;
    end else if (place) begin
      count  <= count + CNT_W'(1);
      lowest <= low_new[COORD_BITS-1:0];
    end
  end

  // Hold the result word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (finish_go) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
    if (finish_go) begin
      out_status     <= status_c;
      out_top        <= (status_c == ST_PLACED) ? cand_y[FIELD_BITS-1:0] : '0;
      out_left       <= (status_c == ST_PLACED) ? cand_x : '0;
      out_rest_valid <= low_new < sh_w;
      out_rest_top   <= (low_new < sh_w) ? low_new[FIELD_BITS-1:0] : '0;
      out_rest_rows  <= (low_new < sh_w) ?
                        (screen_height - low_new[FIELD_BITS-1:0]) : '0;
    end
  end

  assign out_ch.valid      = out_vld;
  assign out_ch.status     = out_status;
  assign out_ch.top_row    = out_top;
  assign out_ch.left_col   = out_left;
  assign out_ch.rest_valid = out_rest_valid;
  assign out_ch.rest_top   = out_rest_top;
  assign out_ch.rest_rows  = out_rest_rows;

  // Feed the chain head.
  assign ctx.h  = req_h;
  assign ctx.w  = req_w;
  assign ctx.sw = screen_width;
  assign link[0].vld = inject;
  assign link[0].chg = 1'b0;
  assign link[0].y   = cand_y;
  assign link[0].x   = cand_x;

  // Build the chain, one cell per store slot.
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    fbp_cell #(
      .IDX       (i),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tin    (link[i]),
      .ctx    (ctx),
      .count  (count),
      .wr_en  (place),
      .wr_top (y_w[COORD_BITS-1:0]),
      .wr_left(x_w[COORD_BITS-1:0]),
      .wr_rows(h_w[COORD_BITS-1:0]),
      .wr_cols(w_w[COORD_BITS-1:0]),
      .tout   (link[i+1])
    );
  end

  // Checks on control.
  `FBP_ASSERT_NEXT(a_accept_check, clk, rst, accept, state == S_CHECK)
  `FBP_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_BOXES))
  `FBP_ASSERT_NOW(a_tail_in_sweep, clk, rst, link[MAX_BOXES].vld, state == S_SWEEP)
  `FBP_ASSERT_NEXT(a_place_count, clk, rst, place, count == $past(count) + CNT_W'(1))
  `FBP_ASSERT_NOW(a_finish_slot, clk, rst, finish_go, slot_free && state == S_FINISH)

endmodule
